>>> hdl/sine_tone_saturating_mixer_defines.svh
// Assertion macros used by the checker file.
`ifndef SINE_TONE_SATURATING_MIXER_DEFINES_SVH
`define SINE_TONE_SATURATING_MIXER_DEFINES_SVH

// Same-cycle implication.
`define STSM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define STSM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/stsm_pkg.sv
package stsm_pkg;

   localparam int NUM_LANES     = 8;
   localparam int PHASE_BITS    = 32;
   localparam int ROM_ADDR_BITS = 10;
   localparam int SINE_DEPTH    = 1 << ROM_ADDR_BITS;
   localparam int QUARTER_DEPTH = SINE_DEPTH / 4;
   localparam int QUARTER_BITS  = ROM_ADDR_BITS - 2;
   localparam int SAMPLE_BITS   = 16;
   localparam int MAG_BITS      = 15;
   localparam int TONE_BITS     = 16;
   localparam int SUM_BITS      = 18;

   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   typedef enum logic [1:0] {
      CSR_WIDTH_MODE = 2'd0,
      CSR_ACTIVE_CH  = 2'd1,
      CSR_AMPLITUDE  = 2'd2,
      CSR_PHASE_STEP = 2'd3
   } csr_reg_type;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [TONE_BITS-1:0]   tone_type;
   typedef logic [MAG_BITS-1:0]           mag_type;

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
   } stage_en_type;

   typedef mag_type sine_rom_type [QUARTER_DEPTH];

   // quarter-wave sine by fixed-point Taylor series, evaluated at elaboration
   function automatic mag_type quarter_sine(input logic [QUARTER_BITS:0] q);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      longint unsigned r;
      longint          s;
      x  = (longint'(q) * HALF_PI_Q30) / QUARTER_DEPTH;
      x2 = (x * x) >> 30;
      s  = longint'(x);
      t  = x;
      t  = ((t * x2) >> 30) / 6;
      s  = s - longint'(t);
      t  = ((t * x2) >> 30) / 20;
      s  = s + longint'(t);
      t  = ((t * x2) >> 30) / 42;
      s  = s - longint'(t);
      t  = ((t * x2) >> 30) / 72;
      s  = s + longint'(t);
      t  = ((t * x2) >> 30) / 110;
      s  = s - longint'(t);
      t  = ((t * x2) >> 30) / 156;
      s  = s + longint'(t);
      if (s < 0) begin
         s = 0;
      end
      r = (longint'(s) * 32767 + (64'd1 << 29)) >> 30;
      if (r > 64'd32767) begin
         r = 64'd32767;
      end
      return r[MAG_BITS-1:0];
   endfunction

   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      for (int k = 0; k < QUARTER_DEPTH; k++) begin
         rom[k] = quarter_sine((QUARTER_BITS+1)'(k));
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM  = build_sine_rom();
   localparam mag_type      SINE_PEAK = quarter_sine((QUARTER_BITS+1)'(QUARTER_DEPTH));

endpackage

>>> hdl/sine_tone_saturating_mixer.sv
// Adds a sine tone to up to eight channels of each audio frame and saturates
// every sum to the 8-bit or 16-bit signed range. One frame per clock is taken
// while req_stall is low, and each frame passes through registered steps in
// order: phase multiply, quarter-wave sine table, amplitude multiply,
// then eight parallel add/saturate lanes into the output register. Each
// pipeline stage holds its item independently, so frames keep entering while
// the output is stalled until every stage is full. Configuration registers
// may only be written while no frame is in flight.
module sine_tone_saturating_mixer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [31:0]          req_sample_index,
   input  stsm_pkg::sample_type req_ch0_in,
   input  stsm_pkg::sample_type req_ch1_in,
   input  stsm_pkg::sample_type req_ch2_in,
   input  stsm_pkg::sample_type req_ch3_in,
   input  stsm_pkg::sample_type req_ch4_in,
   input  stsm_pkg::sample_type req_ch5_in,
   input  stsm_pkg::sample_type req_ch6_in,
   input  stsm_pkg::sample_type req_ch7_in,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output stsm_pkg::sample_type rsp_ch0_out,
   output stsm_pkg::sample_type rsp_ch1_out,
   output stsm_pkg::sample_type rsp_ch2_out,
   output stsm_pkg::sample_type rsp_ch3_out,
   output stsm_pkg::sample_type rsp_ch4_out,
   output stsm_pkg::sample_type rsp_ch5_out,
   output stsm_pkg::sample_type rsp_ch6_out,
   output stsm_pkg::sample_type rsp_ch7_out,
   output logic [7:0]           rsp_saturated_mask,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [31:0]          csr_data
);
   import stsm_pkg::*;

   logic        width_mode_ff;
   logic        width_mode_in;
   logic [3:0]  active_ch_ff;
   logic [3:0]  active_ch_in;
   logic [15:0] amplitude_ff;
   logic [15:0] amplitude_in;
   logic [31:0] phase_step_ff;
   logic [31:0] phase_step_in;

   logic        v1_ff;
   logic        v1_in;
   logic        v2_ff;
   logic        v2_in;
   logic        v3_ff;
   logic        v3_in;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic        en_out;

   stage_en_type stage_en;

   sample_type  req_ch [NUM_LANES];
   sample_type  ch_s1_ff [NUM_LANES];
   sample_type  ch_s2_ff [NUM_LANES];
   sample_type  ch_s3_ff [NUM_LANES];
   sample_type  lane_out [NUM_LANES];
   logic [NUM_LANES-1:0] lane_clip;
   sample_type  out_ff [NUM_LANES];
   logic [NUM_LANES-1:0] mask_ff;
   tone_type    tone;
   logic        csr_write;

   // configuration
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      width_mode_in = width_mode_ff;
      active_ch_in  = active_ch_ff;
      amplitude_in  = amplitude_ff;
      phase_step_in = phase_step_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_WIDTH_MODE: width_mode_in = csr_data[0];
            CSR_ACTIVE_CH:  active_ch_in  = csr_data[3:0];
            CSR_AMPLITUDE:  amplitude_in  = csr_data[15:0];
            CSR_PHASE_STEP: phase_step_in = csr_data;
            default:        width_mode_in = width_mode_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_mode_ff <= 1'b1;
         active_ch_ff  <= 4'd2;
         amplitude_ff  <= 16'd0;
         phase_step_ff <= 32'd243478870;
      end else begin
         width_mode_ff <= width_mode_in;
         active_ch_ff  <= active_ch_in;
         amplitude_ff  <= amplitude_in;
         phase_step_ff <= phase_step_in;
      end
   end

   // pipeline control: a stage loads when empty or when its item moves on
   assign en_out      = !rsp_valid_ff || !rsp_stall;
   assign stage_en.s3 = !v3_ff || en_out;
   assign stage_en.s2 = !v2_ff || stage_en.s3;
   assign stage_en.s1 = !v1_ff || stage_en.s2;
   assign req_stall   = !stage_en.s1;

   assign v1_in        = stage_en.s1 ? req_valid : v1_ff;
   assign v2_in        = stage_en.s2 ? v1_ff : v2_ff;
   assign v3_in        = stage_en.s3 ? v2_ff : v3_ff;
   assign rsp_valid_in = en_out ? v3_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         v3_ff        <= v3_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ch[0] = req_ch0_in;
   assign req_ch[1] = req_ch1_in;
   assign req_ch[2] = req_ch2_in;
   assign req_ch[3] = req_ch3_in;
   assign req_ch[4] = req_ch4_in;
   assign req_ch[5] = req_ch5_in;
   assign req_ch[6] = req_ch6_in;
   assign req_ch[7] = req_ch7_in;

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_LANES; i++) begin
         if (stage_en.s1) begin
            ch_s1_ff[i] <= req_ch[i];
         end
         if (stage_en.s2) begin
            ch_s2_ff[i] <= ch_s1_ff[i];
         end
         if (stage_en.s3) begin
            ch_s3_ff[i] <= ch_s2_ff[i];
         end
      end
   end

   stsm_tone u_tone (
      .clock        (clock),
      .stage_en     (stage_en),
      .sample_index (req_sample_index),
      .phase_step   (phase_step_ff),
      .amplitude    (amplitude_ff),
      .tone         (tone)
   );

   for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
      stsm_lane u_lane (
         .raw     (ch_s3_ff[g]),
         .tone    (tone),
         .active  (active_ch_ff > 4'(g)),
         .wide    (width_mode_ff),
         .result  (lane_out[g]),
         .clipped (lane_clip[g])
      );
   end

   // merge: lane results and clip flags into the output item
   always_ff @(posedge clock) begin
      if (en_out) begin
         mask_ff <= lane_clip;
         for (int i = 0; i < NUM_LANES; i++) begin
            out_ff[i] <= lane_out[i];
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_saturated_mask = mask_ff;
   assign rsp_ch0_out        = out_ff[0];
   assign rsp_ch1_out        = out_ff[1];
   assign rsp_ch2_out        = out_ff[2];
   assign rsp_ch3_out        = out_ff[3];
   assign rsp_ch4_out        = out_ff[4];
   assign rsp_ch5_out        = out_ff[5];
   assign rsp_ch6_out        = out_ff[6];
   assign rsp_ch7_out        = out_ff[7];

endmodule

>>> hdl/stsm_tone.sv
module stsm_tone (
   input  logic                      clock,
   input  stsm_pkg::stage_en_type    stage_en,
   input  logic [31:0]               sample_index,
   input  logic [31:0]               phase_step,
   input  logic [15:0]               amplitude,
   output stsm_pkg::tone_type        tone
);
   import stsm_pkg::*;

   logic [PHASE_BITS-1:0]    phase_ff;
   logic [PHASE_BITS-1:0]    phase_in;
   mag_type                  mag_ff;
   mag_type                  mag_in;
   logic                     neg_ff;
   logic                     neg_in;
   tone_type                 tone_ff;
   tone_type                 tone_in;

   logic [ROM_ADDR_BITS-1:0] addr;
   logic [1:0]               quad;
   logic [QUARTER_BITS:0]    q;
   logic [2*MAG_BITS-1:0]    prod;
   logic [MAG_BITS-1:0]      scaled;

   assign phase_in = sample_index * phase_step;

   always_comb begin
      addr = phase_ff[PHASE_BITS-1 -: ROM_ADDR_BITS];
      quad = addr[ROM_ADDR_BITS-1 -: 2];
      if (quad[0]) begin
         q = (QUARTER_BITS+1)'(QUARTER_DEPTH) - {1'b0, addr[QUARTER_BITS-1:0]};
      end else begin
         q = {1'b0, addr[QUARTER_BITS-1:0]};
      end
      if (q[QUARTER_BITS]) begin
         mag_in = SINE_PEAK;
      end else begin
         mag_in = SINE_ROM[q[QUARTER_BITS-1:0]];
      end
      neg_in = quad[1];
   end

   always_comb begin
      prod   = (2*MAG_BITS)'(amplitude[15:1]) * (2*MAG_BITS)'(mag_ff);
      scaled = prod[2*MAG_BITS-1 -: MAG_BITS];
      if (neg_ff) begin
         tone_in = -tone_type'({1'b0, scaled});
      end else begin
         tone_in = tone_type'({1'b0, scaled});
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en.s1) begin
         phase_ff <= phase_in;
      end
      if (stage_en.s2) begin
         mag_ff <= mag_in;
         neg_ff <= neg_in;
      end
      if (stage_en.s3) begin
         tone_ff <= tone_in;
      end
   end

   assign tone = tone_ff;

endmodule

>>> hdl/stsm_lane.sv
module stsm_lane (
   input  stsm_pkg::sample_type raw,
   input  stsm_pkg::tone_type   tone,
   input  logic                 active,
   input  logic                 wide,
   output stsm_pkg::sample_type result,
   output logic                 clipped
);
   import stsm_pkg::*;

   localparam logic signed [SUM_BITS-1:0] HI16 = 18'sd32767;
   localparam logic signed [SUM_BITS-1:0] LO16 = -18'sd32768;
   localparam logic signed [SUM_BITS-1:0] HI8  = 18'sd127;
   localparam logic signed [SUM_BITS-1:0] LO8  = -18'sd128;

   sample_type                  x;
   logic signed [SUM_BITS-1:0]  sum;
   logic signed [SUM_BITS-1:0]  hi;
   logic signed [SUM_BITS-1:0]  lo;

   always_comb begin
      if (wide) begin
         x  = raw;
         hi = HI16;
         lo = LO16;
      end else begin
         x  = {{8{raw[7]}}, raw[7:0]};
         hi = HI8;
         lo = LO8;
      end
      sum = SUM_BITS'(x) + SUM_BITS'(tone);
      if (!active) begin
         result  = raw;
         clipped = 1'b0;
      end else if (sum > hi) begin
         result  = hi[SAMPLE_BITS-1:0];
         clipped = 1'b1;
      end else if (sum < lo) begin
         result  = lo[SAMPLE_BITS-1:0];
         clipped = 1'b1;
      end else begin
         result  = sum[SAMPLE_BITS-1:0];
         clipped = 1'b0;
      end
   end

endmodule

>>> hdl/stsm_checker.sv
`include "sine_tone_saturating_mixer_defines.svh"

module stsm_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_ch0_out,
   input logic [15:0] rsp_ch7_out,
   input logic [7:0]  rsp_saturated_mask
);

   `STSM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "rsp item dropped while stalled")

   `STSM_ASSERT_NEXT(a_mask_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_saturated_mask), "mask changed while stalled")

   `STSM_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid, "rsp valid right after reset")

   `STSM_ASSERT_NOW(a_clip0_rail, clock, reset, rsp_valid && rsp_saturated_mask[0], rsp_ch0_out == 16'h7fff || rsp_ch0_out == 16'h8000 || rsp_ch0_out == 16'h007f || rsp_ch0_out == 16'hff80, "ch0 clipped off rail")

   `STSM_ASSERT_NOW(a_clip7_rail, clock, reset, rsp_valid && rsp_saturated_mask[7], rsp_ch7_out == 16'h7fff || rsp_ch7_out == 16'h8000 || rsp_ch7_out == 16'h007f || rsp_ch7_out == 16'hff80, "ch7 clipped off rail")

endmodule

bind sine_tone_saturating_mixer stsm_checker u_stsm_checker (.*);

>>> verif/tb_sine_tone_saturating_mixer.sv
`timescale 1ns / 1ps

module tb_sine_tone_saturating_mixer;
   import stsm_pkg::*;

   localparam int                QUARTER_SPAN = 256;
   localparam longint unsigned   HALF_PI_FIX  = 64'd1686629713;
   localparam int                QUIET_LIMIT  = 1000;
   localparam int                RANDOM_PHASES = 8;
   localparam int                PHASE_FRAMES  = 54;

   typedef struct packed {
      logic [7:0][15:0] lane;
      logic [7:0]       clip;
   } mix_result_type;

   typedef struct {
      bit               is_write;
      csr_reg_type      sel;
      logic [31:0]      wdata;
      logic [31:0]      idx;
      logic [7:0][15:0] chans;
      bit               typed;
      mix_result_type   want;
   } plan_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_sample_index = '0;
   sample_type  req_ch0_in = '0;
   sample_type  req_ch1_in = '0;
   sample_type  req_ch2_in = '0;
   sample_type  req_ch3_in = '0;
   sample_type  req_ch4_in = '0;
   sample_type  req_ch5_in = '0;
   sample_type  req_ch6_in = '0;
   sample_type  req_ch7_in = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   sample_type  rsp_ch0_out;
   sample_type  rsp_ch1_out;
   sample_type  rsp_ch2_out;
   sample_type  rsp_ch3_out;
   sample_type  rsp_ch4_out;
   sample_type  rsp_ch5_out;
   sample_type  rsp_ch6_out;
   sample_type  rsp_ch7_out;
   logic [7:0]  rsp_saturated_mask;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   // typed expectation travels with the item on the input channel
   logic           cur_typed = 1'b0;
   mix_result_type cur_want = '0;

   // shadow of the block's registers, reset values
   logic        cfg_wide = 1'b1;
   logic [3:0]  cfg_lanes = 4'd2;
   logic [15:0] cfg_amp = '0;
   logic [31:0] cfg_step = 32'd243478870;

   int unsigned    quarter_mag [0:QUARTER_SPAN];
   mix_result_type mix_expected [$];
   plan_row_type   plan [$];
   int unsigned frames_in = 0;
   int unsigned results_out = 0;
   int unsigned mismatches = 0;
   int unsigned burst_left = 0;
   int unsigned quiet_cycles = 0;

   sine_tone_saturating_mixer u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_sample_index   (req_sample_index),
      .req_ch0_in         (req_ch0_in),
      .req_ch1_in         (req_ch1_in),
      .req_ch2_in         (req_ch2_in),
      .req_ch3_in         (req_ch3_in),
      .req_ch4_in         (req_ch4_in),
      .req_ch5_in         (req_ch5_in),
      .req_ch6_in         (req_ch6_in),
      .req_ch7_in         (req_ch7_in),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_ch0_out        (rsp_ch0_out),
      .rsp_ch1_out        (rsp_ch1_out),
      .rsp_ch2_out        (rsp_ch2_out),
      .rsp_ch3_out        (rsp_ch3_out),
      .rsp_ch4_out        (rsp_ch4_out),
      .rsp_ch5_out        (rsp_ch5_out),
      .rsp_ch6_out        (rsp_ch6_out),
      .rsp_ch7_out        (rsp_ch7_out),
      .rsp_saturated_mask (rsp_saturated_mask),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always #2 clock = ~clock;

   // quarter-wave sine magnitude, Q2.30 Taylor series to the 13th power
   function automatic int unsigned quarter_wave(int unsigned q);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      longint unsigned r;
      longint          s;
      x  = (64'(q) * HALF_PI_FIX) / 64'(QUARTER_SPAN);
      x2 = (x * x) >> 30;
      s  = longint'(x);
      t  = x;
      for (int n = 1; n <= 6; n++) begin
         t = ((t * x2) >> 30) / 64'(2 * n * (2 * n + 1));
         if (n % 2 == 1) begin
            s = s - longint'(t);
         end else begin
            s = s + longint'(t);
         end
      end
      if (s < 0) begin
         s = 0;
      end
      r = (64'(s) * 64'd32767 + (64'd1 << 29)) >> 30;
      if (r > 64'd32767) begin
         r = 64'd32767;
      end
      return int'(r);
   endfunction

   initial begin
      for (int q = 0; q <= QUARTER_SPAN; q++) begin
         quarter_mag[q] = quarter_wave(q);
      end
   end

   function automatic mix_result_type mix_frame(logic [31:0] idx, logic [7:0][15:0] chans);
      mix_result_type res;
      logic [31:0] phase;
      logic [9:0]  addr;
      int          mag;
      int          tone;
      int          lanes;
      int          lo;
      int          hi;
      int          x;
      int          sum;
      res   = '0;
      phase = idx * cfg_step;
      addr  = phase[31:22];
      if (addr[8]) begin
         mag = quarter_mag[QUARTER_SPAN - int'(addr[7:0])];
      end else begin
         mag = quarter_mag[addr[7:0]];
      end
      tone = (int'(cfg_amp >> 1) * mag) >> 15;
      if (addr[9]) begin
         tone = -tone;
      end
      lanes = (cfg_lanes > 4'd8) ? 8 : int'(cfg_lanes);
      lo    = cfg_wide ? -32768 : -128;
      hi    = cfg_wide ? 32767 : 127;
      for (int i = 0; i < 8; i++) begin
         if (i >= lanes) begin
            res.lane[i] = chans[i];
         end else begin
            if (cfg_wide) begin
               x = $signed(chans[i]);
            end else begin
               x = $signed(chans[i][7:0]);
            end
            sum = x + tone;
            if (sum > hi) begin
               sum = hi;
               res.clip[i] = 1'b1;
            end else if (sum < lo) begin
               sum = lo;
               res.clip[i] = 1'b1;
            end
            res.lane[i] = sum[15:0];
         end
      end
      return res;
   endfunction

   function automatic plan_row_type reg_row(csr_reg_type sel, logic [31:0] value);
      plan_row_type row;
      row.is_write = 1'b1;
      row.sel      = sel;
      row.wdata    = value;
      row.idx      = '0;
      row.chans    = '0;
      row.typed    = 1'b0;
      row.want     = '0;
      return row;
   endfunction

   // lanes are listed 7 down to 0
   function automatic plan_row_type frame_row(logic [31:0] idx, logic [7:0][15:0] chans,
                                              bit typed, logic [7:0][15:0] lanes_out,
                                              logic [7:0] clip);
      plan_row_type row;
      row.is_write  = 1'b0;
      row.sel       = CSR_WIDTH_MODE;
      row.wdata     = '0;
      row.idx       = idx;
      row.chans     = chans;
      row.typed     = typed;
      row.want.lane = lanes_out;
      row.want.clip = clip;
      return row;
   endfunction

   task automatic report_mismatch(string what, int unsigned result_no, logic [15:0] got,
                                  logic [15:0] want);
      if (mismatches < 100) begin
         $display("mismatch at result %0d, %s: got %h, expected %h",
                  result_no, what, got, want);
      end
      mismatches++;
   endtask

   task automatic write_csr(csr_reg_type sel, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= sel;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (sel)
         CSR_WIDTH_MODE: cfg_wide  = value[0];
         CSR_ACTIVE_CH:  cfg_lanes = value[3:0];
         CSR_AMPLITUDE:  cfg_amp   = value[15:0];
         CSR_PHASE_STEP: cfg_step  = value;
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // block goes idle: input quiet, every result back, pipeline flushed
   task automatic settle();
      req_valid  <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (mix_expected.size() != 0);
      repeat (6) @(posedge clock);
   endtask

   task automatic send_frame(logic [31:0] idx, logic [7:0][15:0] chans, bit typed,
                             mix_result_type want);
      int unsigned gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         burst_left = $urandom_range(1, 30);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid        <= 1'b1;
      req_sample_index <= idx;
      req_ch0_in       <= chans[0];
      req_ch1_in       <= chans[1];
      req_ch2_in       <= chans[2];
      req_ch3_in       <= chans[3];
      req_ch4_in       <= chans[4];
      req_ch5_in       <= chans[5];
      req_ch6_in       <= chans[6];
      req_ch7_in       <= chans[7];
      cur_typed        <= typed;
      cur_want         <= want;
      do @(posedge clock); while (req_stall);
   endtask

   always @(posedge clock) begin
      mix_result_type want;
      mix_result_type got;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            if (cur_typed) begin
               mix_expected.push_back(cur_want);
            end else begin
               mix_expected.push_back(mix_frame(req_sample_index,
                  {req_ch7_in, req_ch6_in, req_ch5_in, req_ch4_in,
                   req_ch3_in, req_ch2_in, req_ch1_in, req_ch0_in}));
            end
            frames_in++;
         end
         if (rsp_valid && !rsp_stall) begin
            got.lane = {rsp_ch7_out, rsp_ch6_out, rsp_ch5_out, rsp_ch4_out,
                        rsp_ch3_out, rsp_ch2_out, rsp_ch1_out, rsp_ch0_out};
            got.clip = rsp_saturated_mask;
            if (mix_expected.size() == 0) begin
               report_mismatch("result with nothing expected", results_out,
                               got.lane[0], '0);
            end else begin
               want = mix_expected.pop_front();
               for (int i = 0; i < 8; i++) begin
                  if (got.lane[i] !== want.lane[i]) begin
                     report_mismatch($sformatf("ch%0d_out", i), results_out,
                                     got.lane[i], want.lane[i]);
                  end
               end
               if (got.clip !== want.clip) begin
                  report_mismatch("saturated_mask", results_out,
                                  {8'h00, got.clip}, {8'h00, want.clip});
               end
            end
            results_out++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   // receiver pacing; one long hold-off once the stream is running
   initial begin : rsp_pacing
      int unsigned pick;
      int unsigned run;
      bit          long_done;
      long_done = 1'b0;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (!long_done && frames_in >= 40 && req_valid) begin
            long_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (120) @(posedge clock);
         end else begin
            pick = $urandom_range(0, 5);
            run  = $urandom_range(8, 64);
            if (pick == 5) begin
               rsp_stall <= 1'b1;
               repeat (run) @(posedge clock);
            end else begin
               repeat (run) begin
                  case (pick)
                     0:       rsp_stall <= 1'b0;
                     1:       rsp_stall <= ($urandom_range(0, 3) == 0);
                     2:       rsp_stall <= ($urandom_range(0, 1) == 0);
                     default: rsp_stall <= ($urandom_range(0, 3) != 0);
                  endcase
                  @(posedge clock);
               end
            end
         end
      end
   end

   initial begin : stimulus
      logic [31:0]      sidx;
      logic [31:0]      amp_word;
      logic [31:0]      step_word;
      logic [31:0]      lane_word;
      logic [7:0][15:0] chans;
      int unsigned      pick;

      plan.push_back(frame_row(32'h1234_5678,
         {16'h0000, 16'h7FFF, 16'h8000, 16'h1234, 16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF}, 1,
         {16'h0000, 16'h7FFF, 16'h8000, 16'h1234, 16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF},
         8'h00));
      plan.push_back(frame_row(32'hFFFF_FFFF,
         {16'h1357, 16'h9BDF, 16'h2468, 16'hACE0, 16'h7F01, 16'h80FE, 16'h0F0F, 16'hF0F0}, 0,
         '0, '0));
      plan.push_back(reg_row(CSR_AMPLITUDE, 32'h0000_FFFF));
      plan.push_back(reg_row(CSR_PHASE_STEP, 32'h4000_0000));
      // zero phase, no tone
      plan.push_back(frame_row(32'h0000_0000,
         {16'h0000, 16'h7FFF, 16'h8000, 16'h1234, 16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF}, 1,
         {16'h0000, 16'h7FFF, 16'h8000, 16'h1234, 16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF},
         8'h00));
      // positive peak clips high
      plan.push_back(frame_row(32'h0000_0001,
         {16'h5555, 16'hAAAA, 16'h0001, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h0100, 16'h7FFF}, 1,
         {16'h5555, 16'hAAAA, 16'h0001, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF},
         8'h03));
      // negative peak clips low
      plan.push_back(frame_row(32'h0000_0003,
         {16'h1234, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'hFF00, 16'h8000}, 1,
         {16'h1234, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'h8000, 16'h8000},
         8'h03));
      plan.push_back(frame_row(32'h0000_0002,
         {16'h1234, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'hFF00, 16'h8000}, 1,
         {16'h1234, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'hFF00, 16'h8000},
         8'h00));
      plan.push_back(frame_row(32'h0000_0005,
         {16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h0000}, 0,
         '0, '0));
      plan.push_back(frame_row(32'hFFFF_FFFF,
         {16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h7FFF}, 0,
         '0, '0));
      // count above eight acts as eight
      plan.push_back(reg_row(CSR_ACTIVE_CH, 32'h0000_000F));
      plan.push_back(frame_row(32'h0000_0001,
         {16'h0100, 16'h7FFF, 16'h1000, 16'h0200, 16'h4000, 16'h0101, 16'h7FFF, 16'h0100}, 1,
         {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF},
         8'hFF));
      plan.push_back(frame_row(32'h0000_0003,
         {16'hFF00, 16'h8000, 16'hF000, 16'hFE00, 16'hC000, 16'hFEFF, 16'h8000, 16'hFF00}, 1,
         {16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000},
         8'hFF));
      plan.push_back(reg_row(CSR_ACTIVE_CH, 32'h0000_0000));
      plan.push_back(frame_row(32'h0000_0001,
         {16'h5555, 16'hAAAA, 16'h0001, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h0100, 16'h7FFF}, 1,
         {16'h5555, 16'hAAAA, 16'h0001, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h0100, 16'h7FFF},
         8'h00));
      // 8-bit samples
      plan.push_back(reg_row(CSR_WIDTH_MODE, 32'h0000_0000));
      plan.push_back(reg_row(CSR_ACTIVE_CH, 32'h0000_0005));
      plan.push_back(frame_row(32'h0000_0001,
         {16'hABCD, 16'h8000, 16'h7FFF, 16'h0080, 16'h7F00, 16'hFF80, 16'h0000, 16'h12FF}, 1,
         {16'hABCD, 16'h8000, 16'h7FFF, 16'h007F, 16'h007F, 16'h007F, 16'h007F, 16'h007F},
         8'h1F));
      plan.push_back(frame_row(32'h0000_0003,
         {16'hABCD, 16'h8000, 16'h7FFF, 16'h0080, 16'h7F00, 16'hFF80, 16'h0000, 16'h12FF}, 1,
         {16'hABCD, 16'h8000, 16'h7FFF, 16'hFF80, 16'hFF80, 16'hFF80, 16'hFF80, 16'hFF80},
         8'h1F));
      plan.push_back(reg_row(CSR_AMPLITUDE, 32'h0000_00FF));
      plan.push_back(reg_row(CSR_PHASE_STEP, 32'h0100_0000));
      plan.push_back(frame_row(32'h0000_0010,
         {16'h1234, 16'h5678, 16'h9A7F, 16'hBC80, 16'hDE7F, 16'h0F80, 16'h3301, 16'h44FE}, 0,
         '0, '0));
      plan.push_back(frame_row(32'h0000_0030,
         {16'h1234, 16'h5678, 16'h9A7F, 16'hBC80, 16'hDE7F, 16'h0F80, 16'h3301, 16'h44FE}, 0,
         '0, '0));
      plan.push_back(frame_row(32'h0000_00C0,
         {16'h0000, 16'h0000, 16'h0000, 16'h0080, 16'h7F81, 16'h1100, 16'hFF80, 16'h0080}, 0,
         '0, '0));
      plan.push_back(frame_row(32'h0000_0040,
         {16'h0000, 16'h0000, 16'h0000, 16'h007F, 16'h7F81, 16'h1100, 16'hFF7E, 16'h007F}, 0,
         '0, '0));
      // no tone: active lanes are the sign-extended low byte
      plan.push_back(reg_row(CSR_AMPLITUDE, 32'h0000_0001));
      plan.push_back(frame_row(32'h0000_0040,
         {16'hABCD, 16'h8000, 16'h7FFF, 16'h007F, 16'h3480, 16'h12FF, 16'hFF00, 16'h0001}, 1,
         {16'hABCD, 16'h8000, 16'h7FFF, 16'h007F, 16'hFF80, 16'hFFFF, 16'h0000, 16'h0001},
         8'h00));
      // upper data bits beyond each register's width are dropped
      plan.push_back(reg_row(CSR_WIDTH_MODE, 32'hFFFF_FFFF));
      plan.push_back(reg_row(CSR_AMPLITUDE, 32'hABCD_1235));
      plan.push_back(reg_row(CSR_PHASE_STEP, 32'hFFFF_FFFF));
      plan.push_back(reg_row(CSR_ACTIVE_CH, 32'h0000_0018));
      plan.push_back(frame_row(32'hFFFF_FFFF,
         {16'h7000, 16'h9000, 16'h0123, 16'hFEDC, 16'h7FFF, 16'h8000, 16'h7F00, 16'h80FF}, 0,
         '0, '0));
      plan.push_back(frame_row(32'h8000_0000,
         {16'h7000, 16'h9000, 16'h0123, 16'hFEDC, 16'h7FFF, 16'h8000, 16'h7F00, 16'h80FF}, 0,
         '0, '0));
      plan.push_back(frame_row(32'h0012_3456,
         {16'h7000, 16'h9000, 16'h0123, 16'hFEDC, 16'h7FFF, 16'h8000, 16'h7F00, 16'h80FF}, 0,
         '0, '0));
      plan.push_back(frame_row(32'hDEAD_BEEF,
         {16'h7000, 16'h9000, 16'h0123, 16'hFEDC, 16'h7FFF, 16'h8000, 16'h7F00, 16'h80FF}, 0,
         '0, '0));

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[r]) begin
         if (plan[r].is_write) begin
            settle();
            write_csr(plan[r].sel, plan[r].wdata);
         end else begin
            send_frame(plan[r].idx, plan[r].chans, plan[r].typed, plan[r].want);
         end
      end

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         settle();
         amp_word  = $urandom();
         step_word = $urandom();
         lane_word = $urandom();
         case (ph)
            0: begin
               amp_word[15:0] = 16'hFFFF;
               lane_word[3:0] = 4'd8;
            end
            1: begin
               amp_word[15:0] = 16'h0000;
               step_word      = 32'h0000_0000;
               lane_word[3:0] = 4'd1;
            end
            2: begin
               step_word      = 32'hFFFF_FFFF;
               lane_word[3:0] = 4'd15;
            end
            3: amp_word[15:0] = 16'($urandom_range(0, 600));
            4: step_word      = $urandom_range(1, 4096);
            default: ;
         endcase
         write_csr(CSR_WIDTH_MODE, $urandom());
         write_csr(CSR_ACTIVE_CH, lane_word);
         write_csr(CSR_AMPLITUDE, amp_word);
         write_csr(CSR_PHASE_STEP, step_word);
         sidx = $urandom();
         for (int k = 0; k < PHASE_FRAMES; k++) begin
            if ($urandom_range(0, 7) == 0) begin
               sidx = $urandom();
            end else begin
               sidx = sidx + 32'd1;
            end
            for (int c = 0; c < 8; c++) begin
               pick = $urandom_range(0, 5);
               case (pick)
                  4: begin
                     case ($urandom_range(0, 6))
                        0:       chans[c] = 16'h7FFF;
                        1:       chans[c] = 16'h8000;
                        2:       chans[c] = 16'h0000;
                        3:       chans[c] = 16'hFFFF;
                        4:       chans[c] = 16'h007F;
                        5:       chans[c] = 16'h0080;
                        default: chans[c] = 16'hFF80;
                     endcase
                  end
                  5:       chans[c] = 16'($urandom_range(0, 600) - 300);
                  default: chans[c] = 16'($urandom());
               endcase
            end
            send_frame(sidx, chans, 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (mix_expected.size() != 0);
      repeat (10) @(posedge clock);
      if (mismatches == 0 && mix_expected.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+hdl
hdl/stsm_pkg.sv
hdl/stsm_tone.sv
hdl/stsm_lane.sv
hdl/sine_tone_saturating_mixer.sv
hdl/stsm_checker.sv
verif/tb_sine_tone_saturating_mixer.sv
